>>> rtl/flpt_pkg.sv
// Shared types and constants for the four-level page table walker.
package flpt_pkg;

  localparam int unsigned VaW    = 48;
  localparam int unsigned PaW    = 52;
  localparam int unsigned EntryW = 64;
  // Entry and base bits 51:12 hold a frame number.
  localparam int unsigned FrameW = 40;

  localparam logic MODE_REQ   = 1'b0;
  localparam logic MODE_ENTRY = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] PK_4K = 2'd0;
  localparam logic [1:0] PK_2M = 2'd1;
  localparam logic [1:0] PK_1G = 2'd2;

  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitPs      = 7;
  localparam int unsigned BitProto   = 10;
  localparam int unsigned BitTrans   = 11;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic              is_req;
    logic [VaW-1:0]    vaddr;
    logic              present;
    logic              ps;
    logic [FrameW-1:0] frame;
  } item_t;

  typedef struct packed {
    logic           kind;
    logic [PaW-1:0] read_address;
    logic [PaW-1:0] xlat_addr;
    logic           found;
    logic [1:0]     page_kind;
  } result_t;

endpackage

>>> rtl/flpt_fifo.sv
// Small register queue used between front and back and at the result side.
module flpt_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("queue empty after a lone push");
`endif

endmodule

>>> rtl/flpt_front.sv
// Front end: decodes an incoming item and tests entry presence.
module flpt_front (
  input  logic                           mode_i,
  input  logic [flpt_pkg::VaW-1:0]       virt_addr_i,
  input  logic [flpt_pkg::EntryW-1:0]    table_entry_i,
  input  logic                           read_error_i,
  output flpt_pkg::item_t                item_o
);

  logic [flpt_pkg::EntryW-1:0] entry;

  // A failed read counts as an all-zero entry.
  assign entry = read_error_i ? '0 : table_entry_i;

  always_comb begin
    item_o.is_req  = (mode_i == flpt_pkg::MODE_REQ);
    item_o.vaddr   = virt_addr_i;
    item_o.present = entry[flpt_pkg::BitPresent]
                     || (entry[flpt_pkg::BitTrans] && !entry[flpt_pkg::BitProto]);
    item_o.ps      = entry[flpt_pkg::BitPs];
    item_o.frame   = entry[51:12];
  end

endmodule

>>> rtl/flpt_back.sv
// Back end: holds the walk level and latched address and forms each result.
module flpt_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [flpt_pkg::PaW-1:0] cfg_data_i,
  input  logic                     item_valid_i,
  input  flpt_pkg::item_t          item_i,
  output logic                     item_pop_o,
  output logic                     res_push_o,
  output flpt_pkg::result_t        res_o,
  input  logic                     res_full_i
);

  typedef enum logic [2:0] {
    LVL_IDLE,
    LVL_L1,
    LVL_L2,
    LVL_L3,
    LVL_L4
  } level_e;

  level_e                     level_q, level_d;
  logic [flpt_pkg::VaW-1:0]   vaddr_q, vaddr_d;
  logic [flpt_pkg::PaW-1:0]   base_q;
  flpt_pkg::result_t          res;

  assign item_pop_o = item_valid_i && !res_full_i;
  assign res_push_o = item_pop_o;
  assign res_o      = res;

  always_comb begin
    res     = '0;
    level_d = level_q;
    vaddr_d = vaddr_q;
    res.kind = flpt_pkg::KIND_DONE;
    priority if (item_i.is_req) begin
      level_d          = LVL_L1;
      vaddr_d          = item_i.vaddr;
      res.kind         = flpt_pkg::KIND_READ;
      res.read_address = {base_q[51:12], item_i.vaddr[47:39], 3'b000};
    end else if (!item_i.present) begin
      level_d = LVL_IDLE;
    end else begin
      unique case (level_q)
        LVL_L1: begin
          level_d          = LVL_L2;
          res.kind         = flpt_pkg::KIND_READ;
          res.read_address = {item_i.frame, vaddr_q[38:30], 3'b000};
        end
        LVL_L2: begin
          if (item_i.ps) begin
            level_d       = LVL_IDLE;
            res.xlat_addr = {item_i.frame[39:18], vaddr_q[29:0]};
            res.found     = 1'b1;
            res.page_kind = flpt_pkg::PK_1G;
          end else begin
            level_d          = LVL_L3;
            res.kind         = flpt_pkg::KIND_READ;
            res.read_address = {item_i.frame, vaddr_q[29:21], 3'b000};
          end
        end
        LVL_L3: begin
          if (item_i.ps) begin
            level_d       = LVL_IDLE;
            res.xlat_addr = {item_i.frame[39:9], vaddr_q[20:0]};
            res.found     = 1'b1;
            res.page_kind = flpt_pkg::PK_2M;
          end else begin
            level_d          = LVL_L4;
            res.kind         = flpt_pkg::KIND_READ;
            res.read_address = {item_i.frame, vaddr_q[20:12], 3'b000};
          end
        end
        LVL_L4: begin
          level_d       = LVL_IDLE;
          res.xlat_addr = {item_i.frame, vaddr_q[11:0]};
          res.found     = 1'b1;
          res.page_kind = flpt_pkg::PK_4K;
        end
        default: begin
          // Entry with no walk in flight: finish, not found.
          level_d = LVL_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_IDLE;
      vaddr_q <= '0;
      base_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (item_pop_o) begin
        level_q <= level_d;
        vaddr_q <= vaddr_d;
      end
    end
  end

`ifndef SYNTH
  a_req_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && item_i.is_req) |=> level_q == LVL_L1)
    else $error("request did not start a walk at the top level");

  a_found_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.found) |-> (res_o.kind == flpt_pkg::KIND_DONE
                                     && res_o.read_address == '0))
    else $error("found result carries a read request");
`endif

endmodule

>>> rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker.
// Input side is a queue: drive the item fields and raise push; the item is
// taken on a clock edge where push is high and full is low. mode_i 0 starts a
// translation of virt_addr_i, mode_i 1 returns a table entry (table_entry_i,
// read_error_i) for the walk in flight.
// Result side is a queue: while empty is low the oldest result is on the
// result ports; raise pop to take it. Each input item yields exactly one
// result: a read request (kind_o 0, read_address_o) or a finished
// translation (kind_o 1, found_o, xlat_addr_o, page_kind_o).
// The table base is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. Write it only while no item is in flight.
// An accepted item is registered in the middle queue, and its result in the
// result queue before it shows on the ports. One item per cycle is sustained
// while the result queue is not full; the walk state is a single register stage.
// Reset empties both queues, clears the table base and leaves no walk open.
// When pop stays low the result queue fills, the back end stops, and full
// rises once the middle queue also fills; nothing is dropped.
module four_level_page_table_walker #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [flpt_pkg::PaW-1:0]      cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          mode_i,
  input  logic [flpt_pkg::VaW-1:0]      virt_addr_i,
  input  logic [flpt_pkg::EntryW-1:0]   table_entry_i,
  input  logic                          read_error_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind_o,
  output logic [flpt_pkg::PaW-1:0]      read_address_o,
  output logic [flpt_pkg::PaW-1:0]      xlat_addr_o,
  output logic                          found_o,
  output logic [1:0]                    page_kind_o
);

  localparam int unsigned ItemW = $bits(flpt_pkg::item_t);
  localparam int unsigned ResW  = $bits(flpt_pkg::result_t);

  flpt_pkg::item_t   front_item, back_item;
  flpt_pkg::result_t back_res, out_res;
  logic              mid_empty, mid_pop;
  logic              res_push, res_full;

  assign cfg_ready_o = 1'b1;

  flpt_front u_front (
    .mode_i        (mode_i),
    .virt_addr_i   (virt_addr_i),
    .table_entry_i (table_entry_i),
    .read_error_i  (read_error_i),
    .item_o        (front_item)
  );

  flpt_fifo #(
    .Width (ItemW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (back_item),
    .empty_o (mid_empty)
  );

  flpt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (!mid_empty),
    .item_i       (back_item),
    .item_pop_o   (mid_pop),
    .res_push_o   (res_push),
    .res_o        (back_res),
    .res_full_i   (res_full)
  );

  flpt_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign kind_o         = out_res.kind;
  assign read_address_o = out_res.read_address;
  assign xlat_addr_o    = out_res.xlat_addr;
  assign found_o        = out_res.found;
  assign page_kind_o    = out_res.page_kind;

endmodule

>>> dv/tb_four_level_page_table_walker.sv
// Testbench for the four-level page table walker: directed and random walks.
`timescale 1ns / 100ps

module tb_four_level_page_table_walker;

  typedef enum logic [2:0] {
    WALK_IDLE = 3'd0,
    WALK_L1   = 3'd1,
    WALK_L2   = 3'd2,
    WALK_L3   = 3'd3,
    WALK_L4   = 3'd4
  } walk_lvl_e;

  // Predicts the walker and checks each popped result against the oldest prediction.
  class xlate_scoreboard;
    logic [flpt_pkg::PaW-1:0] table_base;
    walk_lvl_e                level;
    logic [flpt_pkg::VaW-1:0] held_va;
    flpt_pkg::result_t        pending_results[$];
    int                       mismatches;
    int                       n_reads, n_4k, n_2m, n_1g, n_miss;

    function new();
      table_base = '0;
      level      = WALK_IDLE;
      held_va    = '0;
      mismatches = 0;
      n_reads = 0; n_4k = 0; n_2m = 0; n_1g = 0; n_miss = 0;
    endfunction

    function logic [flpt_pkg::PaW-1:0] table_addr(logic [flpt_pkg::PaW-1:0] frame_src,
                                                  logic [8:0] idx);
      return {frame_src[flpt_pkg::PaW-1:12], 12'b0} | {40'b0, idx, 3'b0};
    endfunction

    function void take_item(logic m, logic [flpt_pkg::VaW-1:0] va,
                            logic [flpt_pkg::EntryW-1:0] ent, logic err);
      flpt_pkg::result_t           r;
      logic [flpt_pkg::EntryW-1:0] e;
      r = '0;
      e = err ? '0 : ent;
      if (m == flpt_pkg::MODE_REQ) begin
        held_va = va;
        level = WALK_L1;
        r.kind = flpt_pkg::KIND_READ;
        r.read_address = table_addr(table_base, va[47:39]);
      end else if (level == WALK_IDLE) begin
        r.kind = flpt_pkg::KIND_DONE;
      end else if (!(e[flpt_pkg::BitPresent]
                     || (e[flpt_pkg::BitTrans] && !e[flpt_pkg::BitProto]))) begin
        level = WALK_IDLE;
        r.kind = flpt_pkg::KIND_DONE;
      end else begin
        case (level)
          WALK_L1: begin
            level = WALK_L2;
            r.kind = flpt_pkg::KIND_READ;
            r.read_address = table_addr(e[flpt_pkg::PaW-1:0], held_va[38:30]);
          end
          WALK_L2: begin
            if (e[flpt_pkg::BitPs]) begin
              level = WALK_IDLE;
              r = '{kind: flpt_pkg::KIND_DONE, read_address: '0,
                    xlat_addr: {e[51:30], held_va[29:0]},
                    found: 1'b1, page_kind: flpt_pkg::PK_1G};
            end else begin
              level = WALK_L3;
              r.kind = flpt_pkg::KIND_READ;
              r.read_address = table_addr(e[flpt_pkg::PaW-1:0], held_va[29:21]);
            end
          end
          WALK_L3: begin
            if (e[flpt_pkg::BitPs]) begin
              level = WALK_IDLE;
              r = '{kind: flpt_pkg::KIND_DONE, read_address: '0,
                    xlat_addr: {e[51:21], held_va[20:0]},
                    found: 1'b1, page_kind: flpt_pkg::PK_2M};
            end else begin
              level = WALK_L4;
              r.kind = flpt_pkg::KIND_READ;
              r.read_address = table_addr(e[flpt_pkg::PaW-1:0], held_va[20:12]);
            end
          end
          default: begin
            level = WALK_IDLE;
            r = '{kind: flpt_pkg::KIND_DONE, read_address: '0,
                  xlat_addr: {e[51:12], held_va[11:0]},
                  found: 1'b1, page_kind: flpt_pkg::PK_4K};
          end
        endcase
      end
      if (r.kind == flpt_pkg::KIND_READ) n_reads++;
      else if (!r.found) n_miss++;
      else if (r.page_kind == flpt_pkg::PK_1G) n_1g++;
      else if (r.page_kind == flpt_pkg::PK_2M) n_2m++;
      else n_4k++;
      pending_results.push_back(r);
    endfunction

    function void compare(string fname, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (mismatches < 10)
          $display("%0t: %s mismatch, expected %h got %h", $realtime, fname, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(flpt_pkg::result_t got);
      flpt_pkg::result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with none expected, kind %b", $realtime, got.kind);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare("kind", 64'(want.kind), 64'(got.kind));
      compare("read_address", 64'(want.read_address), 64'(got.read_address));
      compare("xlat_addr", 64'(want.xlat_addr), 64'(got.xlat_addr));
      compare("found", 64'(want.found), 64'(got.found));
      compare("page_kind", 64'(want.page_kind), 64'(got.page_kind));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [flpt_pkg::PaW-1:0]      cfg_data_i;
  logic                          push;
  logic                          full;
  logic                          mode_i;
  logic [flpt_pkg::VaW-1:0]      virt_addr_i;
  logic [flpt_pkg::EntryW-1:0]   table_entry_i;
  logic                          read_error_i;
  logic                          empty;
  logic                          pop;
  logic                          kind_o;
  logic [flpt_pkg::PaW-1:0]      read_address_o;
  logic [flpt_pkg::PaW-1:0]      xlat_addr_o;
  logic                          found_o;
  logic [1:0]                    page_kind_o;

  xlate_scoreboard sb;
  bit quick;          // no idling on either side
  int hold_cycles;    // long receiver stall, taken by the receiver process
  int n_items;
  int n_bases;

  four_level_page_table_walker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .virt_addr_i    (virt_addr_i),
    .table_entry_i  (table_entry_i),
    .read_error_i   (read_error_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .read_address_o (read_address_o),
    .xlat_addr_o    (xlat_addr_o),
    .found_o        (found_o),
    .page_kind_o    (page_kind_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [flpt_pkg::VaW-1:0] rand_va();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[flpt_pkg::VaW-1:0];
  endfunction

  function automatic logic [flpt_pkg::EntryW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [flpt_pkg::EntryW-1:0] make_entry(bit present, bit ps);
    logic [flpt_pkg::EntryW-1:0] e;
    e = rand64();
    if (present) begin
      if ($urandom_range(0, 1)) begin
        e[flpt_pkg::BitPresent] = 1'b1;
      end else begin
        e[flpt_pkg::BitPresent] = 1'b0;
        e[flpt_pkg::BitTrans]   = 1'b1;
        e[flpt_pkg::BitProto]   = 1'b0;
      end
    end else begin
      e[flpt_pkg::BitPresent] = 1'b0;
      if ($urandom_range(0, 1)) e[flpt_pkg::BitTrans] = 1'b0;
      else e[flpt_pkg::BitProto] = 1'b1;
    end
    e[flpt_pkg::BitPs] = ps;
    return e;
  endfunction

  task automatic send_item(logic m, logic [flpt_pkg::VaW-1:0] va,
                           logic [flpt_pkg::EntryW-1:0] ent, logic err);
    int gap;
    gap = quick ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    mode_i        <= m;
    virt_addr_i   <= va;
    table_entry_i <= ent;
    read_error_i  <= err;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.take_item(m, va, ent, err);
    n_items++;
  endtask

  // Hold the input side until every expected result is back, then let the pipe settle.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(logic [flpt_pkg::PaW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.table_base = value;
    n_bases++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_walk();
    send_item(flpt_pkg::MODE_REQ, rand_va(), rand64(), 1'($urandom_range(0, 1)));
    while (sb.level != WALK_IDLE) begin
      case ($urandom_range(0, 19))
        0: send_item(flpt_pkg::MODE_REQ, rand_va(), rand64(), 1'($urandom_range(0, 1)));
        1: send_item(flpt_pkg::MODE_ENTRY, rand_va(),
                     make_entry(1'b1, 1'($urandom_range(0, 1))), 1'b1);
        default: send_item(flpt_pkg::MODE_ENTRY, rand_va(),
                           make_entry($urandom_range(0, 11) != 0, $urandom_range(0, 2) == 0),
                           1'b0);
      endcase
    end
  endtask

  // Receiver: pop with random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    flpt_pkg::result_t got;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quick ? 0 : $urandom_range(0, 5);
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got.kind         = kind_o;
      got.read_address = read_address_o;
      got.xlat_addr    = xlat_addr_o;
      got.found        = found_o;
      got.page_kind    = page_kind_o;
      sb.check_result(got);
    end
  end

  initial begin
    logic [flpt_pkg::VaW-1:0] va;
    logic [flpt_pkg::PaW-1:0] bases[5];
    int target;
    int guard;
    sb = new();
    quick = 1'b0;
    hold_cycles = 0;
    n_items = 0;
    n_bases = 0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    mode_i        <= flpt_pkg::MODE_REQ;
    virt_addr_i   <= '0;
    table_entry_i <= '0;
    read_error_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: low base bits must be masked off.
    write_base({20'($urandom_range(1, 1 << 19)), $urandom} | 52'hfff);
    send_item(flpt_pkg::MODE_ENTRY, '0, '1, 1'b0);        // entry while idle
    send_item(flpt_pkg::MODE_REQ, '1, '0, 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, '1, 1'b0);        // page-size bit at top is ignored
    send_item(flpt_pkg::MODE_ENTRY, '0, 64'h0000_0123_4567_8800, 1'b0);  // present via bit 11
    send_item(flpt_pkg::MODE_ENTRY, '0, 64'hfff0_0abc_def0_1001, 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, '1, 1'b0);        // page-size bit at last level ignored
    send_item(flpt_pkg::MODE_REQ, '0, '1, 1'b1);
    send_item(flpt_pkg::MODE_ENTRY, '1, make_entry(1'b1, 1'b0), 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '1, make_entry(1'b1, 1'b1), 1'b0);  // 1 GiB page
    va = rand_va();
    send_item(flpt_pkg::MODE_REQ, va, '0, 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, make_entry(1'b1, 1'b0), 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, make_entry(1'b1, 1'b0), 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, make_entry(1'b1, 1'b1), 1'b0);  // 2 MiB page
    send_item(flpt_pkg::MODE_REQ, rand_va(), '0, 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, '1, 1'b1);        // read error drops a good entry
    send_item(flpt_pkg::MODE_REQ, rand_va(), '0, 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, make_entry(1'b1, 1'b0), 1'b0);
    send_item(flpt_pkg::MODE_REQ, rand_va(), '0, 1'b0);   // restart while busy
    send_item(flpt_pkg::MODE_ENTRY, '0, 64'h0000_0000_0000_0c00, 1'b0);  // bit 11 with bit 10
    send_item(flpt_pkg::MODE_REQ, rand_va(), '0, 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, make_entry(1'b1, 1'b0), 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, make_entry(1'b1, 1'b0), 1'b0);
    send_item(flpt_pkg::MODE_ENTRY, '0, '0, 1'b0);        // zero entry at level 3
    send_item(flpt_pkg::MODE_ENTRY, '0, '1, 1'b1);        // idle again, with read error

    bases[0] = '0;
    bases[1] = '1;
    bases[2] = {20'($urandom_range(0, (1 << 20) - 1)), $urandom};
    bases[3] = {20'($urandom_range(0, (1 << 20) - 1)), $urandom};
    bases[4] = {20'hfffff, 32'h0000_0000};
    for (int ph = 0; ph < 5; ph++) begin
      write_base(bases[ph]);
      quick = (ph == 3);
      // Stall the receiver long enough for full to rise while items keep coming.
      if (ph == 1) hold_cycles = 80;
      target = n_items + 106;
      while (n_items < target) begin
        if ($urandom_range(0, 6) == 0)
          send_item(1'($urandom_range(0, 1)), rand_va(), rand64(), 1'($urandom_range(0, 1)));
        else
          random_walk();
      end
    end
    quick = 1'b0;
    push <= 1'b0;

    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending_results.size() != 0)
      $display("%0d expected results never arrived", sb.pending_results.size());
    $display("Sent %0d items over %0d table bases, %0d mismatches.",
             n_items, n_bases, sb.mismatches);
    $display("Results: %0d reads, %0d 4K, %0d 2M, %0d 1G, %0d not found.",
             sb.n_reads, sb.n_4k, sb.n_2m, sb.n_1g, sb.n_miss);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/flpt_pkg.sv
rtl/flpt_fifo.sv
rtl/flpt_front.sv
rtl/flpt_back.sv
rtl/four_level_page_table_walker.sv
dv/tb_four_level_page_table_walker.sv
